// ===== sv/byte_stuffed_reply_deframer_unit_defines.svh =====
// Assertion macros shared by the reply deframer RTL.
`ifndef BYTE_STUFFED_REPLY_DEFRAMER_UNIT_DEFINES_SVH
`define BYTE_STUFFED_REPLY_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BSRD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bsrd check failed");

// Next-cycle implication, checked out of reset.
`define BSRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bsrd check failed");

`endif

// ===== sv/bsrd_pkg.sv =====
// Types and constants of the byte stuffed reply deframer.
package bsrd_pkg;

  localparam logic [7:0] MARK_START = 8'hFE;
  localparam logic [7:0] MARK_END   = 8'hFC;
  localparam logic [7:0] STUFF_ZERO = 8'h00;
  localparam logic [7:0] CMD_ANY    = 8'h0A;
  localparam logic [7:0] CMD_READ   = 8'h04;
  localparam logic [7:0] CMD_WRITE  = 8'h06;

  localparam int unsigned MIN_PACKET   = 11;
  localparam int unsigned MARKER_BYTES = 4;
  localparam int unsigned LEN_W        = 10;
  localparam logic [LEN_W-1:0] MIN_BODY  = LEN_W'(MIN_PACKET - MARKER_BYTES);
  localparam logic [LEN_W-1:0] COUNT_MAX = '1;

  // Frame status codes
  localparam logic [2:0] FS_MATCHED       = 3'd0;
  localparam logic [2:0] FS_TOO_SHORT     = 3'd1;
  localparam logic [2:0] FS_ADDR_MISMATCH = 3'd2;
  localparam logic [2:0] FS_BAD_CMD       = 3'd3;
  localparam logic [2:0] FS_WRONG_REG     = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGISTER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_KIND    = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic CMD_KIND_READ = 1'b0;

  typedef struct packed {
    logic [7:0]  master_address;
    logic [7:0]  device_address;
    logic [15:0] register_address;
    logic        command_kind;
  } bsrd_cfg_t;

  typedef struct packed {
    logic [7:0]       body_byte;
    logic             frame_end;
    logic [2:0]       frame_status;
    logic [15:0]      received_crc;
    logic [LEN_W-1:0] body_length;
  } bsrd_result_t;

  // Up to two results produced by one item
  typedef struct packed {
    logic [1:0]   count;
    bsrd_result_t r0;
    bsrd_result_t r1;
  } bsrd_push_t;

endpackage

// ===== sv/bsrd_intf.sv =====
// Handshake channel interfaces of the reply deframer.
interface bsrd_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] rx_byte;
  modport source (output valid, restart, rx_byte, input ready);
  modport sink (input valid, restart, rx_byte, output ready);
endinterface

interface bsrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  body_byte;
  logic        frame_end;
  logic [2:0]  frame_status;
  logic [15:0] received_crc;
  logic [9:0]  body_length;
  modport source (output valid, body_byte, frame_end, frame_status, received_crc,
                  body_length, input ready);
  modport sink (input valid, body_byte, frame_end, frame_status, received_crc,
                body_length, output ready);
endinterface

interface bsrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/bsrd_parser.sv =====
// Input register, frame parser state and result formation.
`include "byte_stuffed_reply_deframer_unit_defines.svh"
module bsrd_parser
  import bsrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       restart_i,
  input  logic [7:0] rx_byte_i,
  output logic       in_ready_o,
  input  bsrd_cfg_t  cfg_i,
  input  logic       room_i,
  output bsrd_push_t push_o
);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_ONE_FE = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  typedef struct packed {
    logic [1:0]       phase;
    logic             pending_fc;
    logic             drop_zero;
    logic [LEN_W-1:0] count;
    logic [7:0]       dest;
    logic [7:0]       src;
    logic [7:0]       cmd;
    logic [15:0]      regaddr;
    logic [15:0]      last_two;
  } parse_state_t;

  logic         item_valid_q;
  logic         restart_q;
  logic [7:0]   byte_q;
  logic         fire;
  parse_state_t st_q, st_d;
  bsrd_push_t   push;
  logic         do_plain;

  function automatic parse_state_t emit_body(parse_state_t s, logic [7:0] b);
    parse_state_t n;
    n = s;
    unique case (s.count)
      10'd0:   n.dest = b;
      10'd1:   n.src = b;
      10'd2:   n.cmd = b;
      10'd3:   n.regaddr[7:0] = b;
      10'd4:   n.regaddr[15:8] = b;
      default: ;
    endcase
    if (s.count != COUNT_MAX) n.count = s.count + 1'b1;
    n.last_two = {b, s.last_two[15:8]};
    return n;
  endfunction

  function automatic bsrd_result_t body_result(logic [7:0] b, logic [LEN_W-1:0] len);
    bsrd_result_t r;
    r.body_byte    = b;
    r.frame_end    = 1'b0;
    r.frame_status = FS_MATCHED;
    r.received_crc = '0;
    r.body_length  = len;
    return r;
  endfunction

  function automatic bsrd_result_t close_result(parse_state_t s, bsrd_cfg_t c);
    bsrd_result_t r;
    logic         cmd_ok;
    cmd_ok = (s.cmd == CMD_ANY) ||
             (c.command_kind == CMD_KIND_READ && s.cmd == CMD_READ) ||
             (c.command_kind != CMD_KIND_READ && s.cmd == CMD_WRITE);
    r.body_byte    = '0;
    r.frame_end    = 1'b1;
    r.received_crc = s.last_two;
    r.body_length  = s.count;
    priority if (s.count < MIN_BODY) r.frame_status = FS_TOO_SHORT;
    else if (s.dest != c.master_address || s.src != c.device_address)
      r.frame_status = FS_ADDR_MISMATCH;
    else if (!cmd_ok) r.frame_status = FS_BAD_CMD;
    else if (s.cmd != CMD_ANY && s.regaddr != c.register_address)
      r.frame_status = FS_WRONG_REG;
    else r.frame_status = FS_MATCHED;
    return r;
  endfunction

  assign fire       = item_valid_q && room_i;
  assign in_ready_o = !item_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      restart_q <= restart_i;
      byte_q    <= rx_byte_i;
    end
  end

  always_comb begin
    st_d     = st_q;
    push     = '0;
    do_plain = 1'b0;
    if (fire) begin
      if (restart_q) begin
        st_d = '0;
      end else if (st_q.phase != PH_BODY) begin
        if (st_q.phase == PH_ONE_FE) begin
          st_d.phase = (byte_q == MARK_START) ? PH_BODY : PH_HUNT;
        end else begin
          st_d.phase = (byte_q == MARK_START) ? PH_ONE_FE : PH_HUNT;
        end
      end else if (st_q.pending_fc) begin
        st_d.pending_fc = 1'b0;
        if (byte_q == MARK_END) begin
          push.count = 2'd1;
          push.r0    = close_result(st_q, cfg_i);
          st_d       = '0;
        end else begin
          // held FC was data after all
          st_d       = emit_body(st_d, MARK_END);
          push.count = 2'd1;
          push.r0    = body_result(MARK_END, st_d.count);
          do_plain   = (byte_q != STUFF_ZERO);
        end
      end else if (st_q.drop_zero) begin
        st_d.drop_zero = 1'b0;
        do_plain       = (byte_q != STUFF_ZERO);
      end else begin
        do_plain = 1'b1;
      end

      if (do_plain) begin
        if (byte_q == MARK_END) begin
          st_d.pending_fc = 1'b1;
        end else begin
          st_d = emit_body(st_d, byte_q);
          if (push.count == 2'd0) push.r0 = body_result(byte_q, st_d.count);
          else push.r1 = body_result(byte_q, st_d.count);
          push.count = push.count + 2'd1;
          if (byte_q == MARK_START) st_d.drop_zero = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign push_o = push;

  `BSRD_ASSERT_NOW(a_no_push_when_idle, clk_i, rst_ni, !fire, push.count == 2'd0)
  `BSRD_ASSERT_NEXT(a_close_clears, clk_i, rst_ni, fire && push.r0.frame_end && push.count != 2'd0, st_q.phase == PH_HUNT && st_q.count == '0)
  `BSRD_ASSERT_NOW(a_fc_drop_exclusive, clk_i, rst_ni, 1'b1, !(st_q.pending_fc && st_q.drop_zero))

endmodule

// ===== sv/bsrd_result_fifo.sv =====
// Four-entry result queue taking up to two results per cycle.
`include "byte_stuffed_reply_deframer_unit_defines.svh"
module bsrd_result_fifo
  import bsrd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bsrd_push_t   push_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output bsrd_result_t out_data_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  bsrd_result_t     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CNT_W'(DEPTH - 2));
  assign count_d     = count_q + CNT_W'(push_i.count) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + 1'b1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  `BSRD_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
  `BSRD_ASSERT_NOW(a_push_needs_room, clk_i, rst_ni, push_i.count != 2'd0, room_o)
  `BSRD_ASSERT_NEXT(a_pop_only_drains, clk_i, rst_ni, pop && push_i.count == 2'd0, count_q == $past(count_q) - 1'b1)

endmodule

// ===== sv/byte_stuffed_reply_deframer_unit.sv =====
// Top level of the byte stuffed reply deframer.
//
//  channel    role    payload
//  item_i     sink    restart, rx_byte (raw stuffed byte)
//  result_o   source  body_byte, frame_end, frame_status, received_crc, body_length
//  cfg_i      sink    index (register), data
//
// An item makes zero, one or two results; the input register holds while the result
// queue has fewer than two free entries. Otherwise one item per cycle is accepted.
// An item is captured in the input register; its results go into the queue once the
// queue has room. Results drain one per cycle while result_o is ready.
// Reset clears parser state, queue pointers and all configuration registers.
module byte_stuffed_reply_deframer_unit
  import bsrd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  bsrd_in_if.sink     item_i,
  bsrd_out_if.source  result_o,
  bsrd_cfg_if.sink    cfg_i
);

  bsrd_cfg_t    cfg_q;
  bsrd_push_t   push;
  logic         room;
  bsrd_result_t out_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_MASTER_ADDR: cfg_q.master_address   <= cfg_i.data[7:0];
        REG_DEVICE_ADDR: cfg_q.device_address   <= cfg_i.data[7:0];
        REG_REGISTER:    cfg_q.register_address <= cfg_i.data;
        REG_CMD_KIND:    cfg_q.command_kind     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  bsrd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .restart_i  (item_i.restart),
    .rx_byte_i  (item_i.rx_byte),
    .in_ready_o (item_i.ready),
    .cfg_i      (cfg_q),
    .room_i     (room),
    .push_o     (push)
  );

  bsrd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (out_data)
  );

  assign result_o.body_byte    = out_data.body_byte;
  assign result_o.frame_end    = out_data.frame_end;
  assign result_o.frame_status = out_data.frame_status;
  assign result_o.received_crc = out_data.received_crc;
  assign result_o.body_length  = out_data.body_length;

endmodule

// ===== bench/tb.sv =====
// Testbench of the byte stuffed reply deframer: random framed traffic, self-checking.
`timescale 1ns / 100ps

module tb;
  import bsrd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned CFG_SPACING = 360;

  typedef enum logic [1:0] {
    HUNT_FIRST_FE,
    HUNT_SECOND_FE,
    HUNT_IN_BODY
  } hunt_phase_e;

  // Tracks the deframer state and holds the results it should produce next.
  class deframer_scoreboard;
    logic [7:0]       master_addr;
    logic [7:0]       device_addr;
    logic [15:0]      register_addr;
    logic             cmd_kind;
    hunt_phase_e      phase;
    logic             fc_held;
    logic             zero_drop;
    logic [LEN_W-1:0] body_cnt;
    logic [7:0]       got_dest;
    logic [7:0]       got_src;
    logic [7:0]       got_cmd;
    logic [15:0]      got_reg;
    logic [15:0]      crc_window;
    bsrd_result_t     expected_q[$];
    int unsigned      errors;

    function new();
      master_addr   = '0;
      device_addr   = '0;
      register_addr = '0;
      cmd_kind      = CMD_KIND_READ;
      errors        = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase      = HUNT_FIRST_FE;
      fc_held    = 1'b0;
      zero_drop  = 1'b0;
      body_cnt   = '0;
      got_dest   = '0;
      got_src    = '0;
      got_cmd    = '0;
      got_reg    = '0;
      crc_window = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MASTER_ADDR: master_addr = val[7:0];
        REG_DEVICE_ADDR: device_addr = val[7:0];
        REG_REGISTER:    register_addr = val;
        REG_CMD_KIND:    cmd_kind = val[0];
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] b, logic last, logic [2:0] st, logic [15:0] crc);
      bsrd_result_t r;
      r.body_byte    = b;
      r.frame_end    = last;
      r.frame_status = st;
      r.received_crc = crc;
      r.body_length  = body_cnt;
      expected_q.push_back(r);
    endfunction

    function void take_body(logic [7:0] b);
      case (body_cnt)
        10'd0: got_dest = b;
        10'd1: got_src = b;
        10'd2: got_cmd = b;
        10'd3: got_reg[7:0] = b;
        10'd4: got_reg[15:8] = b;
        default: ;
      endcase
      if (body_cnt != COUNT_MAX) body_cnt++;
      crc_window = {b, crc_window[15:8]};
      push(b, 1'b0, FS_MATCHED, 16'h0000);
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == MARK_END) begin
        fc_held = 1'b1;
      end else begin
        take_body(b);
        if (b == MARK_START) zero_drop = 1'b1;
      end
    endfunction

    function void close_frame();
      logic       cmd_ok;
      logic [2:0] st;
      cmd_ok = (got_cmd == CMD_ANY) ||
               (cmd_kind == CMD_KIND_READ && got_cmd == CMD_READ) ||
               (cmd_kind != CMD_KIND_READ && got_cmd == CMD_WRITE);
      if (body_cnt < MIN_BODY) st = FS_TOO_SHORT;
      else if (got_dest != master_addr || got_src != device_addr) st = FS_ADDR_MISMATCH;
      else if (!cmd_ok) st = FS_BAD_CMD;
      else if (got_cmd != CMD_ANY && got_reg != register_addr) st = FS_WRONG_REG;
      else st = FS_MATCHED;
      push(8'h00, 1'b1, st, crc_window);
      clear_frame();
    endfunction

    function void note_item(logic restart, logic [7:0] b);
      if (restart) begin
        clear_frame();
        return;
      end
      if (phase != HUNT_IN_BODY) begin
        if (phase == HUNT_SECOND_FE)
          phase = (b == MARK_START) ? HUNT_IN_BODY : HUNT_FIRST_FE;
        else
          phase = (b == MARK_START) ? HUNT_SECOND_FE : HUNT_FIRST_FE;
        return;
      end
      if (fc_held) begin
        fc_held = 1'b0;
        if (b == MARK_END) begin
          close_frame();
          return;
        end
        // lone FC was data: emit it, then handle this byte in the same step
        take_body(MARK_END);
        if (b != STUFF_ZERO) plain_byte(b);
        return;
      end
      if (zero_drop) begin
        zero_drop = 1'b0;
        if (b == STUFF_ZERO) return;
      end
      plain_byte(b);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] g, logic [31:0] w);
      if (g !== w) report($sformatf("%s: got %0h, expected %0h", name, g, w));
    endtask

    task check_result(bsrd_result_t got);
      bsrd_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: byte %02h end %0d",
                         got.body_byte, got.frame_end));
        return;
      end
      want = expected_q.pop_front();
      compare_field("body_byte", 32'(got.body_byte), 32'(want.body_byte));
      compare_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
      compare_field("frame_status", 32'(got.frame_status), 32'(want.frame_status));
      compare_field("received_crc", 32'(got.received_crc), 32'(want.received_crc));
      compare_field("body_length", 32'(got.body_length), 32'(want.body_length));
    endtask
  endclass

  logic clk;
  logic rst_n;

  bsrd_in_if  item_if ();
  bsrd_out_if res_if ();
  bsrd_cfg_if cfg_if ();

  byte_stuffed_reply_deframer_unit i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  deframer_scoreboard sb = new();

  logic [7:0]  frame_q[$];
  logic [7:0]  raw_q[$];
  int unsigned items_sent;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned quiet_cycles;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_stall_left;
  int unsigned rx_cycle;
  bsrd_result_t seen_result;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: check accepted results, then pick next ready from the current stall mode
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      seen_result = '{body_byte: res_if.body_byte, frame_end: res_if.frame_end,
                      frame_status: res_if.frame_status,
                      received_crc: res_if.received_crc, body_length: res_if.body_length};
      sb.check_result(seen_result);
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(40, 300);
    end else begin
      rx_mode_left--;
    end
    rx_cycle++;
    case (rx_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= ((rx_cycle % 5) < 3);
      default: begin
        if (rx_stall_left != 0) begin
          rx_stall_left--;
          res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_stall_left = $urandom_range(1, 12);
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog on cycles without any accepted item, result or register write
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task send_item(logic restart, logic [7:0] b);
    item_if.valid   <= 1'b1;
    item_if.restart <= restart;
    item_if.rx_byte <= b;
    do @(posedge clk); while (!item_if.ready);
    sb.note_item(restart, b);
    items_sent++;
  endtask

  // Sender works in bursts; when gaps are on, valid drops between bursts
  task put_byte(logic restart, logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        item_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    send_item(restart, b);
  endtask

  // Hold the sender until every expected result has drained
  task settle();
    item_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_register(idx, val);
  endtask

  task program_config(logic [7:0] m, logic [7:0] d, logic [15:0] r, logic k);
    cfg_write(REG_MASTER_ADDR, {8'h00, m});
    cfg_write(REG_DEVICE_ADDR, {8'h00, d});
    cfg_write(REG_REGISTER, r);
    cfg_write(REG_CMD_KIND, {15'h0000, k});
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return MARK_START;
      1: return MARK_END;
      2: return STUFF_ZERO;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] likely_or_any(logic [7:0] v);
    if ($urandom_range(0, 4) != 0) return v;
    return any_byte();
  endfunction

  function automatic void make_body(int unsigned len);
    logic [7:0] cmd;
    frame_q.delete();
    for (int unsigned i = 0; i < len; i++) begin
      case (i)
        0: frame_q.push_back(likely_or_any(sb.master_addr));
        1: frame_q.push_back(likely_or_any(sb.device_addr));
        2: begin
          case ($urandom_range(0, 5))
            0, 1: cmd = (sb.cmd_kind == CMD_KIND_READ) ? CMD_READ : CMD_WRITE;
            2: cmd = CMD_ANY;
            3: cmd = CMD_READ;
            4: cmd = CMD_WRITE;
            default: cmd = any_byte();
          endcase
          frame_q.push_back(cmd);
        end
        3: frame_q.push_back(likely_or_any(sb.register_addr[7:0]));
        4: frame_q.push_back(likely_or_any(sb.register_addr[15:8]));
        default: frame_q.push_back(any_byte());
      endcase
    end
  endfunction

  // Wrap the body in markers; a sloppy frame sometimes skips the stuffing zero
  function automatic void stuff_frame(bit faithful);
    raw_q.delete();
    raw_q.push_back(MARK_START);
    raw_q.push_back(MARK_START);
    foreach (frame_q[i]) begin
      raw_q.push_back(frame_q[i]);
      if ((frame_q[i] == MARK_START || frame_q[i] == MARK_END) &&
          (faithful || $urandom_range(0, 9) != 0))
        raw_q.push_back(STUFF_ZERO);
    end
    raw_q.push_back(MARK_END);
    raw_q.push_back(MARK_END);
  endfunction

  task send_raw(int unsigned count);
    for (int unsigned i = 0; i < count; i++) put_byte(1'b0, raw_q[i]);
  endtask

  initial begin
    int unsigned next_cfg_at;
    int unsigned cfg_round;
    int unsigned len;
    bit          long_done;

    rst_n           = 1'b0;
    item_if.valid   = 1'b0;
    item_if.restart = 1'b0;
    item_if.rx_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_MASTER_ADDR;
    cfg_if.data     = '0;
    res_if.ready    = 1'b0;
    items_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    quiet_cycles    = 0;
    rx_mode         = 0;
    rx_mode_left    = 0;
    rx_stall_left   = 0;
    rx_cycle        = 0;
    long_done       = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: restart, hunting past a false start, stuffed FE and FC, a lone FC, short frame
    program_config(8'h00, 8'h5A, 16'hFCFE, CMD_KIND_READ);
    put_byte(1'b1, MARK_START);
    raw_q = '{8'hFE, 8'h55, 8'hFE, 8'hFE,
              8'h00, 8'h5A, 8'h04, 8'hFE, 8'h00, 8'hFC, 8'h00, 8'hFC, 8'h37,
              8'h12, 8'hFF, 8'hFC, 8'hFC,
              8'hFE, 8'hFE, 8'h01, 8'hFC, 8'hFC};
    send_raw(raw_q.size());
    settle();

    next_cfg_at = items_sent;
    cfg_round   = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg_at) begin
        settle();
        case (cfg_round % 4)
          0: program_config(8'hFF, 8'hFF, 16'hFFFF, 1'b1);
          1: program_config(8'h00, 8'h00, 16'h0000, CMD_KIND_READ);
          default: program_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        endcase
        cfg_round++;
        next_cfg_at += CFG_SPACING;
      end
      gaps_on = ($urandom_range(0, 4) != 0);
      if (!long_done && items_sent >= 700) begin
        // one frame long enough to saturate the body count
        long_done = 1'b1;
        make_body(1030);
        stuff_frame(1'b1);
        send_raw(raw_q.size());
        continue;
      end
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(1, 4)) put_byte(1'b0, any_byte());
        1: put_byte(1'b1, 8'($urandom_range(0, 255)));
        2: begin
          // broken frame: cut short, often followed by a restart
          make_body($urandom_range(0, 14));
          stuff_frame(1'($urandom_range(0, 1)));
          send_raw($urandom_range(1, raw_q.size()));
          if ($urandom_range(0, 1) != 0) put_byte(1'b1, 8'($urandom_range(0, 255)));
        end
        3: settle();
        default: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 18);
          make_body(len);
          stuff_frame($urandom_range(0, 3) != 0);
          send_raw(raw_q.size());
        end
      endcase
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bsrd_pkg.sv
sv/bsrd_intf.sv
sv/bsrd_parser.sv
sv/bsrd_result_fifo.sv
sv/byte_stuffed_reply_deframer_unit.sv
bench/tb.sv
